### design/pwh_pkg.sv
// Package for the password hash block: widths, constants, shared types and
// the radix-65521 long-division step. No dependencies.
package pwh_pkg;

   localparam int CHAR_W     = 7;
   localparam int HASH_W     = 16;
   localparam int ACC_W      = 64;
   localparam int DIGIT_W    = 16;
   localparam int SUM_W      = 32;
   localparam int CHUNKS     = ACC_W / DIGIT_W;   // 16-bit chunks per dividend
   localparam int DIV_DIGITS = 3;                 // digits taken as remainders
   localparam int DEF_QUEUE_DEPTH = 4;

   localparam logic [DIGIT_W-1:0] MODULUS = 16'd65521;

   // Digit weights, index 0 is the least significant digit
   localparam logic [3:0][DIGIT_W-1:0] WEIGHTS = {16'd45912, 16'd35511, 16'd65169, 16'd4625};

   typedef logic [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic    valid;
      acc_type data;
   } push_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] quo;
      logic [DIGIT_W-1:0] rem;
   } step_type;

   typedef struct packed {
      acc_type                           num;
      acc_type                           quo;
      logic [DIGIT_W-1:0]                rem;
      logic [DIV_DIGITS-1:0][DIGIT_W-1:0] digs;
   } div_type;

   // One long-division step: (rem*2^16 + chunk) / 65521, rem < 65521.
   // 2^16 = 65521 + 15, so the quotient is rem + k with k the small quotient
   // of 15*rem + chunk (< 2^20), which folds once more and needs one subtract.
   function automatic step_type chunk_step(input logic [DIGIT_W-1:0] rem,
                                           input logic [DIGIT_W-1:0] chunk);
      logic [19:0]        y;
      logic [3:0]         k0;
      logic [7:0]         k15;
      logic [16:0]        t;
      logic               carry;
      step_type           res;
      y     = ({4'b0, rem} << 4) - {4'b0, rem} + {4'b0, chunk};
      k0    = y[19:16];
      k15   = {k0, 4'b0} - {4'b0, k0};
      t     = {1'b0, y[15:0]} + {9'b0, k15};
      carry = (t >= {1'b0, MODULUS});
      res.rem = carry ? 16'(t - {1'b0, MODULUS}) : t[15:0];
      res.quo = rem + {12'b0, k0} + {15'b0, carry};
      return res;
   endfunction

endpackage

### design/pwh_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on pwh_pkg.
interface pwh_req_if;
   logic                        valid;
   logic                        ready;
   logic [pwh_pkg::CHAR_W-1:0]  char_code;
   logic                        is_last;
   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface pwh_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pwh_pkg::HASH_W-1:0]  hash_value;
   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

### design/password_hash_base128_mod65521_top.sv
// Top level of the password hash block: front end, queue and back end.
// Uses pwh_pkg, pwh_if, pwh_front, pwh_queue, pwh_back.
//
// Usage:
//  - req channel: one beat per password character (char_code, 7-bit ASCII),
//    first character first; is_last marks the final character. Each beat
//    updates acc = acc*128 + char (mod 2^64); the last beat also closes the
//    password and clears acc.
//  - rsp channel: one beat per password, hash_value in 0..65520, in order.
//  - Throughput: one request beat per cycle while the queue has room; one
//    response per cycle as long as the receiver takes them. Set by the
//    64-bit shift-add in the front end.
//  - Pipeline: the queue entry is written at the edge accepting is_last, then
//    18 pipeline registers: input register, twelve 16-bit long-division
//    stages, digit fixup, multiply, sum and two reduction stages.
//  - Stall: when rsp is held off, the back-end pipeline freezes as a whole;
//    the queue (QUEUE_DEPTH entries) absorbs finished passwords, and req.ready
//    drops only once the queue is full.
//  - Reset (synchronous): clears the accumulator, queue and pipeline valids;
//    rsp.valid is low the cycle after reset.
module password_hash_base128_mod65521_top #(
   parameter int QUEUE_DEPTH = pwh_pkg::DEF_QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   pwh_req_if.sink    req,
   pwh_rsp_if.source  rsp
);
   import pwh_pkg::*;

   push_type push;    // finished accumulator from the front end
   push_type head;    // oldest queued accumulator
   logic     push_ready;
   logic     pop;

   pwh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_ready (push_ready),
      .push       (push)
   );

   pwh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   pwh_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

### design/pwh_front.sv
// Front end: takes character beats, keeps the base-128 accumulator and
// pushes the finished accumulator on the last character. Uses pwh_pkg, pwh_if.
module pwh_front (
   input  logic              clock,
   input  logic              reset,
   pwh_req_if.sink           req,
   input  logic              push_ready,
   output pwh_pkg::push_type push
);
   import pwh_pkg::*;

   acc_type acc_ff;
   acc_type acc_in;
   acc_type acc_next;
   logic    accept;

   assign req.ready = push_ready;
   assign accept    = req.valid && req.ready;
   assign acc_next  = {acc_ff[ACC_W-CHAR_W-1:0], req.char_code};

   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = req.is_last ? '0 : acc_next;
      end
   end

   assign push.valid = accept && req.is_last;
   assign push.data  = acc_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

### design/pwh_queue.sv
// Short queue of finished accumulators between front and back end.
// Uses pwh_pkg.
module pwh_queue #(
   parameter int DEPTH = pwh_pkg::DEF_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  pwh_pkg::push_type push,
   output logic              push_ready,
   output pwh_pkg::push_type head,
   input  logic              pop
);
   import pwh_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   acc_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              wr_en;
   logic              rd_en;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.data  = mem_ff[rd_ptr_ff];
   assign wr_en      = push.valid && push_ready;
   assign rd_en      = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_en ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(wr_en) - CNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

### design/pwh_back.sv
// Back end: pipelined base-65521 digit split, weighted fold and final
// reduction, with the output register. Uses pwh_pkg, pwh_if.
module pwh_back (
   input  logic              clock,
   input  logic              reset,
   input  pwh_pkg::push_type head,
   output logic              pop,
   pwh_rsp_if.source         rsp
);
   import pwh_pkg::*;

   localparam int STEPS = DIV_DIGITS * CHUNKS;  // one 16-bit chunk per stage
   localparam int PIPE  = STEPS + 6;            // div regs + digit, prod, sum, part, out

   div_type                       div_ff [STEPS+1];
   logic [PIPE-1:0]               vld_ff, vld_in;
   logic [3:0][DIGIT_W-1:0]       dig_ff, dig_in;
   logic [3:0][SUM_W-1:0]         prod_ff, prod_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [DIGIT_W-1:0]            part_ff, part_in;
   logic [DIGIT_W-1:0]            lo_ff;
   logic [HASH_W-1:0]             hash_ff, hash_in;
   logic [DIGIT_W:0]              q3;
   step_type                      hi_step, lo_step;
   logic                          advance;

   function automatic div_type div_step(input div_type cur, input int s);
      logic [1:0] j;
      logic [1:0] i;
      step_type   st;
      div_type    nxt;
      j   = 2'(s / CHUNKS);
      i   = 2'(CHUNKS - 1 - s % CHUNKS);
      nxt = cur;
      st  = chunk_step(cur.rem, cur.num[DIGIT_W*i +: DIGIT_W]);
      nxt.quo[DIGIT_W*i +: DIGIT_W] = st.quo;
      nxt.rem = st.rem;
      if (i == 2'd0) begin
         // division done: remainder is a digit, quotient is the next dividend
         nxt.digs[j] = st.rem;
         nxt.num     = nxt.quo;
         nxt.quo     = '0;
         nxt.rem     = '0;
      end
      return nxt;
   endfunction

   assign advance = !vld_ff[PIPE-1] || rsp.ready;
   assign pop     = advance && head.valid;
   assign vld_in  = {vld_ff[PIPE-2:0], head.valid};

   // Top quotient is below twice the modulus
   assign q3 = div_ff[STEPS].num[DIGIT_W:0];

   always_comb begin
      dig_in[0] = div_ff[STEPS].digs[0];
      dig_in[1] = div_ff[STEPS].digs[1];
      dig_in[2] = div_ff[STEPS].digs[2];
      dig_in[3] = (q3 >= {1'b0, MODULUS}) ? 16'(q3 - {1'b0, MODULUS}) : q3[DIGIT_W-1:0];
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = {16'b0, dig_ff[k]} * {16'b0, WEIGHTS[k]};
      end
      sum_in  = prod_ff[0] + prod_ff[1] + prod_ff[2] + prod_ff[3];
      hi_step = chunk_step('0, sum_ff[SUM_W-1:DIGIT_W]);
      part_in = hi_step.rem;
      lo_step = chunk_step(part_ff, lo_ff);
      hash_in = lo_step.rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0].num  <= head.data;
         div_ff[0].quo  <= '0;
         div_ff[0].rem  <= '0;
         div_ff[0].digs <= '0;
         for (int s = 0; s < STEPS; s++) begin
            div_ff[s+1] <= div_step(div_ff[s], s);
         end
         dig_ff  <= dig_in;
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         part_ff <= part_in;
         lo_ff   <= sum_ff[DIGIT_W-1:0];
         hash_ff <= hash_in;
      end
   end

   assign rsp.valid      = vld_ff[PIPE-1];
   assign rsp.hash_value = hash_ff;

endmodule

### design/pwh_checker.sv
// Port-level checker for the password hash top level, bound in below.
// Depends on pwh_pkg and password_hash_base128_mod65521_top.
module pwh_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [pwh_pkg::HASH_W-1:0] rsp_hash_value
);
   import pwh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hash_value))
      else $error("rsp payload changed while stalled");

   a_hash_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hash_value < MODULUS))
      else $error("hash not reduced below modulus");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind password_hash_base128_mod65521_top pwh_checker u_pwh_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_hash_value (rsp.hash_value)
);
